@@ src/sha512_pkg.sv @@
`default_nettype none
package sha512_pkg;

  localparam int WordW  = 64;
  localparam int Rounds = 80;

  typedef logic [WordW-1:0] word_t;

  localparam word_t IvTab [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t KTab [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

@@ src/sha512_if.sv @@
`default_nettype none
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] lane;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, lane, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, lane, data_byte, first_byte, last_byte, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_lane;
  logic [2:0]  word_index;
  logic [63:0] digest_word;
  logic        last_word;
  modport source (output valid, out_lane, word_index, digest_word, last_word, input ready);
  modport sink (input valid, out_lane, word_index, digest_word, last_word, output ready);
endinterface
`default_nettype wire

@@ src/sha512_multilane_hasher_top.sv @@
`default_nettype none
// Channel   Dir  Fields
// in_ch     in   lane, data_byte, first_byte, last_byte
// out_ch    out  out_lane, word_index, digest_word, last_word
//
// A byte that does not fill a block is accepted, then read, merged and
// written back; a first byte also first reloads the lane's chain value.
// A byte that completes a block adds a compression: block-memory reads,
// chain reads, 80 rounds of the one round unit and chain write-back.
// A last byte adds a padding pass and one compression, or a second
// padding pass and a second compression when the length no longer fits,
// then 8 digest words, each held until out_ch.ready, and a reload of the
// lane's chain value.
// No item is taken until all of that is done.
// Reset is synchronous; the chain memory is reloaded with the initial value
// by a clearing pass over all LANES*8 words, during which no item is taken.
module sha512_multilane_hasher_top
  import sha512_pkg::*;
#(
  parameter int LANES = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);
  localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int BAW = LW + 4;
  localparam int CAW = LW + 3;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RD    = 13'b0000000000100,
    S_WR    = 13'b0000000001000,
    S_LOADB = 13'b0000000010000,
    S_LOADC = 13'b0000000100000,
    S_ROUND = 13'b0000001000000,
    S_ADD   = 13'b0000010000000,
    S_PADRD = 13'b0000100000000,
    S_PAD   = 13'b0001000000000,
    S_EMIT  = 13'b0010000000000,
    S_RESTA = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state;

  // Memories.
  word_t block_mem [LANES*16];
  word_t chain_mem [LANES*8];
  word_t block_rd, chain_rd;
  logic [BAW-1:0] b_raddr, b_waddr;
  logic           b_we;
  word_t          b_wdata;
  logic [CAW-1:0] c_raddr, c_waddr;
  logic           c_we;
  word_t          c_wdata;

  always_ff @(posedge clk) begin
    if (b_we) block_mem[b_waddr] <= b_wdata;
    block_rd <= block_mem[b_raddr];
  end
  always_ff @(posedge clk) begin
    if (c_we) chain_mem[c_waddr] <= c_wdata;
    chain_rd <= chain_mem[c_raddr];
  end

  logic [63:0]    byte_count [LANES];
  logic [LW-1:0]  cur_lane;
  logic [7:0]     cur_byte;
  logic           cur_last;
  logic [6:0]     off;
  logic [6:0]     cnt;
  logic [CAW-1:0] clr_idx;
  logic [1:0]     pad_left;   // padding compressions still to run, this one included
  logic           pad_two;
  logic           emit_done;
  logic [63:0]    total;
  word_t          v [8];
  word_t          v_next [8];
  word_t          wwin [16];
  word_t          w_cur, w_new, w15, w2;
  word_t          merged;
  logic [2:0]     widx;

  sha512_round u_round (
    .v_in (v),
    .w    (w_cur),
    .k    (KTab[cnt]),
    .v_out(v_next)
  );

  always_comb begin
    w15   = wwin[1];
    w2    = wwin[14];
    w_new = wwin[0] + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7)) + wwin[9]
          + (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6));
    w_cur = (cnt < 7'd16) ? wwin[0] : w_new;
  end

  // Byte merge into the word just read.
  always_comb begin
    merged = block_rd;
    merged[(7 - off[2:0]) * 8 +: 8] = cur_byte;
  end

  assign in_ch.ready = (state == S_IDLE);
  wire accept = in_ch.valid && in_ch.ready && (32'(in_ch.lane) < LANES);

  always_comb begin
    b_raddr = {cur_lane, off[6:3]};
    b_we    = 1'b0;
    b_waddr = {cur_lane, off[6:3]};
    b_wdata = merged;
    c_raddr = {cur_lane, cnt[2:0]};
    c_we    = 1'b0;
    c_waddr = {cur_lane, cnt[2:0]};
    c_wdata = chain_rd + v[0];
    unique case (state)
      S_CLR, S_RESTA: begin
        c_we    = 1'b1;
        c_waddr = clr_idx;
        c_wdata = IvTab[clr_idx[2:0]];
      end
      S_IDLE: b_raddr = {LW'(in_ch.lane), in_ch.first_byte ? 4'd0
                         : byte_count[LW'(in_ch.lane)][6:3]};
      S_WR: b_we = 1'b1;
      S_LOADB: b_raddr = {cur_lane, cnt[3:0]};
      S_ADD: begin
        c_we    = (cnt != 7'd0);
        c_waddr = {cur_lane, cnt[2:0] - 3'd1};
      end
      S_PAD: begin
        // Words before the marker keep their message bytes; the second
        // padding block is all zero apart from the length.
        b_we    = (pad_left == 2'd1) || (cnt[3:0] >= off[6:3]);
        b_waddr = {cur_lane, cnt[3:0]};
        b_wdata = '0;
        if (pad_left != 2'd1 && cnt[3:0] == off[6:3]) begin
          b_wdata = block_rd;
          b_wdata[(7 - off[2:0]) * 8 +: 8] = 8'h80;
          for (int j = 0; j < 8; j++)
            if (j > off[2:0]) b_wdata[(7 - j) * 8 +: 8] = 8'h00;
        end
        if (pad_left != 2'd2 && !pad_two) begin
          if (cnt[3:0] == 4'd14) b_wdata = {61'd0, total[63:61]};
          if (cnt[3:0] == 4'd15) b_wdata = {total[60:0], 3'd0};
        end
      end
      S_PADRD: b_raddr = {cur_lane, off[6:3]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      emit_done <= 1'b0;
      for (int i = 0; i < LANES; i++) byte_count[i] <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == LANES*8-1) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          cur_lane <= LW'(in_ch.lane);
          cur_byte <= in_ch.data_byte;
          cur_last <= in_ch.last_byte;
          emit_done <= 1'b0;
          if (in_ch.first_byte) begin
            off <= '0;
            byte_count[LW'(in_ch.lane)] <= 64'd1;
            clr_idx <= {LW'(in_ch.lane), 3'd0};
          end else begin
            off <= byte_count[LW'(in_ch.lane)][6:0];
            byte_count[LW'(in_ch.lane)] <= byte_count[LW'(in_ch.lane)] + 64'd1;
          end
          pad_left <= 2'd0;
          pad_two  <= 1'b0;
          state <= in_ch.first_byte ? S_RESTA : S_RD;
        end
        S_RESTA: begin
          // Restart: reload the lane's chain with the initial value.
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx[2:0] == 3'd7) state <= emit_done ? S_IDLE : S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          cnt <= '0;
          total <= byte_count[cur_lane];
          if (off == 7'd127) state <= S_LOADB;
          else if (cur_last) state <= S_PADRD;
          else state <= S_IDLE;
        end
        S_PADRD: begin
          off <= total[6:0];
          pad_two <= (total[6:0] >= 7'd112);
          cnt <= '0;
          state <= S_PAD;
        end
        S_PAD: begin
          if (cnt[3:0] == 4'd15) begin
            cnt <= '0;
            state <= S_LOADB;
            pad_left <= pad_two ? 2'd2 : 2'd1;
          end else cnt <= cnt + 7'd1;
        end
        S_LOADB: begin
          // cnt selects the block read; each load stores the registered read of the previous cnt.
          if (cnt != 7'd0) wwin[cnt[3:0] - 4'd1] <= block_rd;
          if (cnt == 7'd16) begin
            cnt <= '0;
            state <= S_LOADC;
          end else cnt <= cnt + 7'd1;
        end
        S_LOADC: begin
          if (cnt != 7'd0) v[cnt[2:0] - 3'd1] <= chain_rd;
          if (cnt == 7'd8) begin
            cnt <= '0;
            state <= S_ROUND;
          end else cnt <= cnt + 7'd1;
        end
        S_ROUND: begin
          v <= v_next;
          for (int i = 0; i < 15; i++) wwin[i] <= wwin[i+1];
          wwin[15] <= w_cur;
          if (cnt == 7'(Rounds - 1)) begin
            cnt <= '0;
            state <= S_ADD;
          end else cnt <= cnt + 7'd1;
        end
        S_ADD: begin
          // cnt selects the chain read; each add uses the registered read of the previous cnt.
          if (cnt != 7'd0) begin
            for (int i = 0; i < 7; i++) v[i] <= v[i+1];
          end
          if (cnt == 7'd8) begin
            cnt <= '0;
            if (pad_left == 2'd2) begin
              // Second padding block: all zero but the length.
              pad_left <= 2'd1;
              pad_two  <= 1'b0;
              off      <= '0;
              state    <= S_PAD;
            end else if (pad_left == 2'd1) begin
              widx  <= '0;
              state <= S_EMIT;
            end else if (cur_last) state <= S_PADRD;
            else state <= S_IDLE;
          end else cnt <= cnt + 7'd1;
        end
        S_EMIT: begin
          // chain_rd holds word widx; the next word is read while it waits.
          out_ch.valid       <= 1'b1;
          out_ch.out_lane    <= 3'(cur_lane);
          out_ch.word_index  <= widx;
          out_ch.digest_word <= chain_rd;
          out_ch.last_word   <= (widx == 3'd7);
          cnt   <= {4'd0, widx + 3'd1};
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          widx <= widx + 3'd1;
          if (widx == 3'd7) begin
            byte_count[cur_lane] <= '0;
            clr_idx <= {cur_lane, 3'd0};
            emit_done <= 1'b1;
            state <= S_RESTA;
          end else state <= S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (state == S_OUT))
    else $error("result held outside output state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (cnt < 7'(Rounds)))
    else $error("round counter out of range");
  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result waits");
endmodule
`default_nettype wire

@@ src/sha512_round.sv @@
`default_nettype none
// One SHA-512 round over the registered working variables.
module sha512_round
  import sha512_pkg::*;
(
  input  word_t v_in  [8],
  input  word_t w,
  input  word_t k,
  output word_t v_out [8]
);
  word_t t1, t2, s1, s0, ch, maj;

  always_comb begin
    s1  = rotr(v_in[4], 14) ^ rotr(v_in[4], 18) ^ rotr(v_in[4], 41);
    ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    s0  = rotr(v_in[0], 28) ^ rotr(v_in[0], 34) ^ rotr(v_in[0], 39);
    maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t1  = v_in[7] + s1 + ch + k + w;
    t2  = s0 + maj;
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end
endmodule
`default_nettype wire
